@@ hw/rtl/sfb_pkg.sv @@
package sfb_pkg;

   localparam int unsigned BYTE_W    = 8;
   localparam int unsigned STEP_W    = 3;
   localparam int unsigned CSR_IDX_W = 1;
   localparam int unsigned REQ_DATA_W = 3 * BYTE_W;
   localparam int unsigned RSP_DATA_W = BYTE_W;

   localparam logic [BYTE_W-1:0] HEAD_RESET    = 8'hAA;
   localparam logic [BYTE_W-1:0] ADDRESS_RESET = 8'h00;

   typedef enum logic {
      REQ_START = 1'b0,
      REQ_DATA  = 1'b1
   } req_kind_type;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_HEAD    = 1'b0,
      CSR_ADDRESS = 1'b1
   } csr_index_type;

   typedef enum logic [STEP_W-1:0] {
      STEP_0 = 3'd0,
      STEP_1 = 3'd1,
      STEP_2 = 3'd2,
      STEP_3 = 3'd3,
      STEP_4 = 3'd4,
      STEP_5 = 3'd5
   } step_type;

   typedef logic [BYTE_W-1:0] byte_type;

   typedef struct packed {
      req_kind_type kind;
      byte_type     frame_id;
      byte_type     frame_len;
      byte_type     data_byte;
   } item_type;

   typedef struct packed {
      byte_type frame_head;
      byte_type frame_address;
   } cfg_type;

   typedef struct packed {
      byte_type out_byte;
      logic     out_last;
      logic     seq_error;
   } result_type;

endpackage

@@ hw/rtl/sfb_engine.sv @@
module sfb_engine (
   input  logic                clock,
   input  logic                reset,
   input  sfb_pkg::cfg_type    cfg,
   input  logic                item_valid,
   output logic                item_ready,
   input  sfb_pkg::item_type   item,
   output logic                res_valid,
   input  logic                res_ready,
   output sfb_pkg::result_type res
);
   import sfb_pkg::*;

   logic       item_vld_ff, item_vld_in;
   item_type   item_ff, item_in;
   step_type   step_ff, step_in;
   logic       open_ff, open_in;
   byte_type   left_ff, left_in;
   byte_type   sum_ff, sum_in;
   byte_type   add_ff, add_in;

   logic       advance;
   logic       final_step;
   logic       summed;
   logic       restart;
   byte_type   summed_byte;
   byte_type   base_sum;
   byte_type   base_add;
   byte_type   sum_new;
   byte_type   add_new;
   byte_type   left_dec;
   result_type res_c;

   assign base_sum = restart ? '0 : sum_ff;
   assign base_add = restart ? '0 : add_ff;
   assign sum_new  = base_sum + summed_byte;
   assign add_new  = base_add + sum_new;
   assign left_dec = left_ff - byte_type'(1);

   always_comb begin
      res_c       = '0;
      final_step  = 1'b0;
      summed      = 1'b0;
      restart     = 1'b0;
      summed_byte = '0;
      open_in     = open_ff;
      left_in     = left_ff;
      case (item_ff.kind)
         REQ_START: begin
            case (step_ff)
               STEP_0: begin
                  if (open_ff) begin
                     res_c.seq_error = 1'b1;
                     final_step      = 1'b1;
                  end else begin
                     summed      = 1'b1;
                     restart     = 1'b1;
                     summed_byte = cfg.frame_head;
                  end
               end
               STEP_1: begin
                  summed      = 1'b1;
                  summed_byte = cfg.frame_address;
               end
               STEP_2: begin
                  summed      = 1'b1;
                  summed_byte = item_ff.frame_id;
               end
               STEP_3: begin
                  summed      = 1'b1;
                  summed_byte = item_ff.frame_len;
                  if (item_ff.frame_len != '0) begin
                     final_step = 1'b1;
                     open_in    = 1'b1;
                     left_in    = item_ff.frame_len;
                  end
               end
               STEP_4: begin
                  res_c.out_byte = sum_ff;
               end
               STEP_5: begin
                  res_c.out_byte = add_ff;
                  res_c.out_last = 1'b1;
                  final_step     = 1'b1;
                  open_in        = 1'b0;
                  left_in        = '0;
               end
               default: begin
                  final_step = 1'b1;
               end
            endcase
         end
         REQ_DATA: begin
            case (step_ff)
               STEP_0: begin
                  if (!open_ff) begin
                     res_c.seq_error = 1'b1;
                     final_step      = 1'b1;
                  end else begin
                     summed      = 1'b1;
                     summed_byte = item_ff.data_byte;
                     left_in     = left_dec;
                     final_step  = (left_dec != '0);
                  end
               end
               STEP_1: begin
                  res_c.out_byte = sum_ff;
               end
               STEP_2: begin
                  res_c.out_byte = add_ff;
                  res_c.out_last = 1'b1;
                  final_step     = 1'b1;
                  open_in        = 1'b0;
                  left_in        = '0;
               end
               default: begin
                  final_step = 1'b1;
               end
            endcase
         end
         default: begin
            final_step = 1'b1;
         end
      endcase
      if (summed) begin
         res_c.out_byte = summed_byte;
      end
   end

   assign advance    = item_vld_ff && res_ready;
   assign item_ready = !item_vld_ff || (res_ready && final_step);
   assign res_valid  = item_vld_ff;
   assign res        = res_c;

   always_comb begin
      item_vld_in = item_vld_ff;
      item_in     = item_ff;
      step_in     = step_ff;
      sum_in      = sum_ff;
      add_in      = add_ff;
      if (advance) begin
         step_in = step_type'(step_ff + STEP_W'(1));
         if (final_step) begin
            item_vld_in = 1'b0;
         end
         if (summed) begin
            sum_in = sum_new;
            add_in = add_new;
         end
      end
      if (item_valid && item_ready) begin
         item_vld_in = 1'b1;
         item_in     = item;
         step_in     = STEP_0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         item_vld_ff <= 1'b0;
         step_ff     <= STEP_0;
         open_ff     <= 1'b0;
         left_ff     <= '0;
         sum_ff      <= '0;
         add_ff      <= '0;
      end else begin
         item_vld_ff <= item_vld_in;
         step_ff     <= step_in;
         sum_ff      <= sum_in;
         add_ff      <= add_in;
         if (advance) begin
            open_ff <= open_in;
            left_ff <= left_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      item_ff <= item_in;
   end

endmodule

@@ hw/rtl/serial_frame_builder_sum_add_check_core.sv @@
// Serial frame builder: a start transaction (tuser 0) emits head, address, id and
// length bytes; each data transaction (tuser 1) passes its byte through; after the
// last payload byte, or right after the header for zero length, the 8-bit sum
// check and add check follow, the add check flagged with tlast. Out-of-sequence
// transactions give one result with tuser 1 and are dropped. The result register
// delivers one byte per cycle unless the response output stalls; an item holds
// the block until it has issued its result bytes: 1 for a passed or rejected
// byte, 3 for the last payload byte, 4 for a start, 6 for a zero-length start.
// Items with one result stream at one per cycle unless stalled; the next item is
// taken in the cycle that issues the previous item's final byte. Configuration writes are always ready.
module serial_frame_builder_sum_add_check_core (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  req_tvalid,
   output logic                                  req_tready,
   input  logic [sfb_pkg::REQ_DATA_W-1:0]        req_tdata,  // frame_id, frame_len, data_byte
   input  logic                                  req_tuser,  // req_type
   output logic                                  rsp_tvalid,
   input  logic                                  rsp_tready,
   output logic [sfb_pkg::RSP_DATA_W-1:0]        rsp_tdata,  // out_byte
   output logic                                  rsp_tlast,
   output logic                                  rsp_tuser,  // seq_error
   input  logic                                  csr_valid,
   output logic                                  csr_ready,
   input  logic [sfb_pkg::CSR_IDX_W-1:0]         csr_index,
   input  logic [sfb_pkg::BYTE_W-1:0]            csr_data
);
   import sfb_pkg::*;

   cfg_type    cfg_ff, cfg_in;
   item_type   item;
   result_type res;
   logic       res_valid;
   logic       res_ready;
   logic       rsp_vld_ff, rsp_vld_in;
   result_type rsp_ff, rsp_in;

   assign csr_ready = 1'b1;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid && csr_ready) begin
         case (csr_index_type'(csr_index))
            CSR_HEAD:    cfg_in.frame_head    = csr_data;
            CSR_ADDRESS: cfg_in.frame_address = csr_data;
            default:     cfg_in = cfg_ff;
         endcase
      end
   end

   assign item.kind      = req_kind_type'(req_tuser);
   assign item.frame_id  = req_tdata[BYTE_W-1:0];
   assign item.frame_len = req_tdata[2*BYTE_W-1:BYTE_W];
   assign item.data_byte = req_tdata[3*BYTE_W-1:2*BYTE_W];

   sfb_engine u_engine (
      .clock      (clock),
      .reset      (reset),
      .cfg        (cfg_ff),
      .item_valid (req_tvalid),
      .item_ready (req_tready),
      .item       (item),
      .res_valid  (res_valid),
      .res_ready  (res_ready),
      .res        (res)
   );

   assign res_ready = !rsp_vld_ff || rsp_tready;

   always_comb begin
      rsp_vld_in = rsp_vld_ff;
      rsp_in     = rsp_ff;
      if (res_ready) begin
         rsp_vld_in = res_valid;
         rsp_in     = res;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.frame_head    <= HEAD_RESET;
         cfg_ff.frame_address <= ADDRESS_RESET;
         rsp_vld_ff           <= 1'b0;
      end else begin
         cfg_ff     <= cfg_in;
         rsp_vld_ff <= rsp_vld_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_ff <= rsp_in;
   end

   assign rsp_tvalid = rsp_vld_ff;
   assign rsp_tdata  = rsp_ff.out_byte;
   assign rsp_tlast  = rsp_ff.out_last;
   assign rsp_tuser  = rsp_ff.seq_error;

endmodule

@@ hw/rtl/sfb_checker.sv @@
module sfb_checker (
   input logic                           clock,
   input logic                           reset,
   input logic                           rsp_tvalid,
   input logic                           rsp_tready,
   input logic [sfb_pkg::RSP_DATA_W-1:0] rsp_tdata,
   input logic                           rsp_tlast,
   input logic                           rsp_tuser,
   input logic                           csr_valid,
   input logic                           csr_ready
);

   a_err_clean: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser |-> rsp_tdata == '0 && !rsp_tlast)
      else $error("error result carries data or tlast");

   a_reset_quiet: assert property (@(posedge clock)
      reset |=> !rsp_tvalid)
      else $error("result valid right after reset");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata)
         && $stable(rsp_tlast) && $stable(rsp_tuser))
      else $error("stalled result changed");

   a_csr_ready: assert property (@(posedge clock) disable iff (reset)
      csr_valid |-> csr_ready)
      else $error("configuration write stalled");

endmodule

bind serial_frame_builder_sum_add_check_core sfb_checker u_sfb_checker (.*);
